### hdl/wpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wpd_pkg;

  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned TIME_IN_BITS  = 48;
  localparam int unsigned WORD_BITS     = 24;
  localparam int unsigned CNT_BITS      = 5;

  localparam logic [15:0] ONE_HIGH_RST  = 16'd700;
  localparam logic [15:0] TOL_RST       = 16'd150;
  localparam logic [19:0] GAP_RST       = 20'd50000;

  localparam int unsigned ADDR_BITS     = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_OWN = 2'd0,
    KIND_FWD = 2'd1,
    KIND_RST = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_ONE_HIGH = 2'd0,
    REG_TOL      = 2'd1,
    REG_GAP      = 2'd2,
    REG_DISABLED = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                    op;
    logic                    level;
    logic [TIME_IN_BITS-1:0] time_ns;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [WORD_BITS-1:0] data;
  } out_item_t;

  typedef struct packed {
    logic [15:0] one_high_ns;
    logic [15:0] bit_tolerance_ns;
    logic [19:0] reset_gap_ns;
    logic        disabled;
  } cfg_t;

endpackage
`default_nettype wire

### hdl/wpd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wpd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/wpd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module wpd_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wpd_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [wpd_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [wpd_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  output wpd_pkg::cfg_t                           cfg_o
);
  import wpd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high_ns      <= ONE_HIGH_RST;
      cfg_q.bit_tolerance_ns <= TOL_RST;
      cfg_q.reset_gap_ns     <= GAP_RST;
      cfg_q.disabled         <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ONE_HIGH: cfg_q.one_high_ns      <= pwdata[15:0];
        REG_TOL:      cfg_q.bit_tolerance_ns <= pwdata[15:0];
        REG_GAP:      cfg_q.reset_gap_ns     <= pwdata[19:0];
        REG_DISABLED: cfg_q.disabled         <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ONE_HIGH: prdata[15:0] = cfg_q.one_high_ns;
      REG_TOL:      prdata[15:0] = cfg_q.bit_tolerance_ns;
      REG_GAP:      prdata[19:0] = cfg_q.reset_gap_ns;
      REG_DISABLED: prdata[0]    = cfg_q.disabled;
    endcase
  end
endmodule
`default_nettype wire

### hdl/wpd_core.sv
`timescale 1ns / 1ps
`default_nettype none
module wpd_core #(
  parameter int unsigned TIME_BITS = wpd_pkg::TIME_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wpd_pkg::cfg_t      cfg_i,
  wpd_stream_if.sink         in_i,
  wpd_stream_if.source       out_o
);
  import wpd_pkg::*;

  // input stage
  logic     s1_valid_q;
  in_item_t s1_q;
  logic     advance;

  // decoder state
  logic [TIME_BITS-1:0] rise_q, rise_d;
  logic [TIME_BITS-1:0] fall_q, fall_d;
  logic [WORD_BITS-2:0] shift_q, shift_d;
  logic [CNT_BITS-1:0]  bits_q, bits_d;
  logic                 fwd_q, fwd_d;

  // result register
  logic      out_valid_q;
  out_item_t out_q;
  logic      res_valid;
  out_item_t res;

  logic [TIME_BITS+TIME_IN_BITS-1:0] now_ext;
  logic [TIME_BITS-1:0]              now;
  logic [TIME_BITS-1:0]              gap_w;
  logic [TIME_BITS-1:0]              high_w;
  logic [16:0]                       lo_bound;
  logic [16:0]                       hi_bound;
  logic                              gap_hit;
  logic                              bit_one;
  logic [WORD_BITS-1:0]              word;
  logic [CNT_BITS-1:0]               bits_inc;

  assign advance     = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~s1_valid_q | advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // timestamps truncate or zero-extend to the internal time width
  assign now_ext = {{TIME_BITS{1'b0}}, s1_q.time_ns};
  assign now     = now_ext[TIME_BITS-1:0];
  assign gap_w   = now - fall_q;
  assign high_w  = now - rise_q;

  // |w - one| <= tol  <=>  max(one - tol, 0) <= w <= one + tol
  assign lo_bound = (cfg_i.one_high_ns >= cfg_i.bit_tolerance_ns) ?
                    {1'b0, cfg_i.one_high_ns - cfg_i.bit_tolerance_ns} : 17'd0;
  assign hi_bound = {1'b0, cfg_i.one_high_ns} + {1'b0, cfg_i.bit_tolerance_ns};

  assign gap_hit  = (|gap_w[TIME_BITS-1:20]) | (gap_w[19:0] >= cfg_i.reset_gap_ns);
  assign bit_one  = ~(|high_w[TIME_BITS-1:17]) &
                    (high_w[16:0] >= lo_bound) & (high_w[16:0] <= hi_bound);
  assign word     = {shift_q, bit_one};
  assign bits_inc = bits_q + CNT_BITS'(1);

  always_comb begin
    rise_d    = rise_q;
    fall_d    = fall_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    fwd_d     = fwd_q;
    res_valid = 1'b0;
    res.kind  = KIND_RST;
    res.data  = '0;
    if (s1_q.op == OP_RESET) begin
      shift_d   = '0;
      bits_d    = '0;
      fwd_d     = 1'b0;
      res_valid = 1'b1;
    end else if (!cfg_i.disabled) begin
      if (s1_q.level) begin
        rise_d = now;
        if (gap_hit) begin
          shift_d = '0;
          bits_d  = '0;
          fwd_d   = 1'b0;
        end
      end else begin
        fall_d  = now;
        shift_d = word[WORD_BITS-2:0];
        bits_d  = bits_inc;
        if (bits_inc == CNT_BITS'(WORD_BITS)) begin
          shift_d   = '0;
          bits_d    = '0;
          fwd_d     = 1'b1;
          res_valid = 1'b1;
          if (fwd_q) begin
            res.kind = KIND_FWD;
            res.data = word;
          end else begin
            // own colour arrives G,R,B; emit R,G,B
            res.kind = KIND_OWN;
            res.data = {word[15:8], word[23:16], word[7:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rise_q      <= '0;
      fall_q      <= '0;
      shift_q     <= '0;
      bits_q      <= '0;
      fwd_q       <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= res_valid;
        rise_q      <= rise_d;
        fall_q      <= fall_d;
        shift_q     <= shift_d;
        bits_q      <= bits_d;
        fwd_q       <= fwd_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q <= in_i.payload;
    end
    if (advance) begin
      out_q <= res;
    end
  end
endmodule
`default_nettype wire

### hdl/ws2812_pulse_decoder_top.sv
// After its input transfer, an item passes the input register and then the result register.
// Throughput: one input item per cycle while the output is not stalled; the state update is a single
// pass of compare-and-shift logic between the input register and the result register.
// A stalled output holds the result register and, through it, the input register.
// Reset (rst_ni low, asynchronous) clears timestamps, shift word, bit count and forwarding
// flag, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module ws2812_pulse_decoder_top #(
  parameter int unsigned TIME_BITS = wpd_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [wpd_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [wpd_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [wpd_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  wpd_stream_if.sink                              in_i,
  wpd_stream_if.source                            out_o
);
  import wpd_pkg::*;

  cfg_t cfg;

  wpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wpd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire
